[rtl/clfsr_pkg.sv]
// Package for the clock-controlled LFSR keystream cipher: widths, codes and LFSR functions.
package clfsr_pkg;

    localparam int unsigned LFSR_BITS  = 128;
    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned GEN_COUNT  = 3;
    localparam int unsigned REKEY_BITS = GEN_COUNT * LFSR_BITS;
    localparam int unsigned CNT_BITS   = $clog2(REKEY_BITS);
    localparam int unsigned CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SEED_HIGH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEED_LOW  = 2'd1;

    localparam logic FUNC_REKEY = 1'b0;
    localparam logic FUNC_CRYPT = 1'b1;

    localparam logic [CNT_BITS-1:0] REKEY_LAST = CNT_BITS'(REKEY_BITS - 1);
    localparam logic [CNT_BITS-1:0] CRYPT_LAST = CNT_BITS'(BYTE_BITS - 1);

    typedef logic [LFSR_BITS-1:0] t_lfsr;

    // Feedback tap: XOR of bits 0, 1, 2 and 7.
    function automatic logic lfsr_fb(input t_lfsr s);
        lfsr_fb = s[0] ^ s[1] ^ s[2] ^ s[7];
    endfunction

    // One clock: shift right, feedback enters at the top.
    function automatic t_lfsr lfsr_clk(input t_lfsr s);
        lfsr_clk = {lfsr_fb(s), s[LFSR_BITS-1:1]};
    endfunction

endpackage

[rtl/clock_controlled_lfsr_keystream_xor_top.sv]
// Clock-controlled LFSR keystream cipher: rekey sequencer and byte encrypt/decrypt engine.
// Crypt request: one decimator step per cycle, the last step held while the output is stalled;
//   a new crypt request is accepted only once the engine is back in idle.
// Rekey request: one seed-LFSR bit shifted into the generator chain per cycle, the last shift
//   held while the output is stalled; a new request is accepted only once the engine is idle.
// Result registered; the next request is taken while a result waits, and the last step holds
// until the output register is free.
// Synchronous active-low reset clears seeds, generators and the output valid.
module clock_controlled_lfsr_keystream_xor_top
    import clfsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [WORD_BITS-1:0]      i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_func,
    input  logic [BYTE_BITS-1:0]      i_data_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [BYTE_BITS-1:0]      o_data_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REKEY,
        S_CRYPT
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [WORD_BITS-1:0]  r_seed_high, n_seed_high;
    logic [WORD_BITS-1:0]  r_seed_low, n_seed_low;
    t_lfsr                 r_scr, n_scr;
    t_lfsr                 r_gen_a, n_gen_a;
    t_lfsr                 r_gen_b, n_gen_b;
    t_lfsr                 r_gen_c, n_gen_c;
    logic [BYTE_BITS-1:0]  r_data, n_data;
    logic [BYTE_BITS-1:0]  r_ks, n_ks;
    logic                  r_out_valid, n_out_valid;
    logic [BYTE_BITS-1:0]  r_out_data, n_out_data;

    logic                  out_free;
    logic                  in_accept;
    logic                  fc;
    logic                  ks_bit;
    t_lfsr                 a1, a2, b1, b2, b3;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;

    // Decimator step: C decides whether A and B take extra clocks.
    always_comb begin
        fc     = lfsr_fb(r_gen_c);
        a1     = lfsr_clk(r_gen_a);
        a2     = lfsr_clk(a1);
        b1     = lfsr_clk(r_gen_b);
        b2     = lfsr_clk(b1);
        b3     = lfsr_clk(b2);
        ks_bit = fc ? (r_gen_a[1] ^ r_gen_b[2]) : (r_gen_a[0] ^ r_gen_b[0]);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_seed_high = r_seed_high;
        n_seed_low  = r_seed_low;
        n_scr       = r_scr;
        n_gen_a     = r_gen_a;
        n_gen_b     = r_gen_b;
        n_gen_c     = r_gen_c;
        n_data      = r_data;
        n_ks        = r_ks;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEED_HIGH: n_seed_high = i_cfg_data;
                CFG_SEED_LOW:  n_seed_low  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cnt  = '0;
                    n_data = i_data_in;
                    if (i_func == FUNC_REKEY) begin
                        n_scr   = {r_seed_high, r_seed_low};
                        n_state = S_REKEY;
                    end else begin
                        n_state = S_CRYPT;
                    end
                end
            end
            S_REKEY: begin
                // Hold the last shift until the output register can take the result.
                if (r_cnt != REKEY_LAST || out_free) begin
                    n_scr = lfsr_clk(r_scr);
                    {n_gen_a, n_gen_b, n_gen_c} =
                        {r_gen_a[LFSR_BITS-2:0], r_gen_b, r_gen_c, r_scr[0]};
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == REKEY_LAST) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                    end
                end
            end
            S_CRYPT: begin
                if (r_cnt != CRYPT_LAST || out_free) begin
                    n_gen_a = fc ? a2 : a1;
                    n_gen_b = fc ? b3 : b1;
                    n_gen_c = lfsr_clk(r_gen_c);
                    n_ks    = {r_ks[BYTE_BITS-2:0], ks_bit};
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt == CRYPT_LAST) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_out_data  = r_data ^ {r_ks[BYTE_BITS-2:0], ks_bit};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_seed_high <= '0;
            r_seed_low  <= '0;
            r_gen_a     <= '0;
            r_gen_b     <= '0;
            r_gen_c     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_seed_high <= n_seed_high;
            r_seed_low  <= n_seed_low;
            r_gen_a     <= n_gen_a;
            r_gen_b     <= n_gen_b;
            r_gen_c     <= n_gen_c;
            r_out_valid <= n_out_valid;
        end
        r_scr      <= n_scr;
        r_data     <= n_data;
        r_ks       <= n_ks;
        r_out_data <= n_out_data;
    end

`ifndef NO_ASSERTIONS
    a_crypt_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRYPT) |-> (r_cnt <= CRYPT_LAST))
        else $error("crypt step counter out of range");

    a_rekey_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REKEY && r_cnt == REKEY_LAST && out_free)
            |=> (r_state == S_IDLE && r_out_valid && r_out_data == '0))
        else $error("rekey did not finish with a zero result");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_cnt == '0 && r_state != S_IDLE))
        else $error("accepted request did not start the sequencer");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state != S_IDLE))
        else $error("result appeared without a running request");
`endif

endmodule
